// ===== hdl/spiral_matrix_order_emitter_defines.svh =====
// Assertion macros shared by the spiral matrix order emitter RTL.
`ifndef SPIRAL_MATRIX_ORDER_EMITTER_DEFINES_SVH
`define SPIRAL_MATRIX_ORDER_EMITTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SMOE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SMOE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/smoe_pkg.sv =====
// Shared constants, types and helper functions of the spiral matrix order emitter.
`default_nettype none

package smoe_pkg;

   // Matrix geometry and storage.
   localparam int MaxRows    = 8;
   localparam int MaxCols    = 8;
   localparam int StoreDepth = MaxRows * MaxCols;
   localparam int AddrW      = $clog2(StoreDepth);
   localparam int RowW       = $clog2(MaxRows);
   localparam int ColW       = $clog2(MaxCols);
   localparam int DimW       = 4;
   localparam int CountW     = $clog2(StoreDepth + 1);
   localparam int DataW      = 32;

   // Two banks let one matrix load while the previous one is walked.
   localparam int Banks      = 2;
   localparam int BankW      = $clog2(Banks);
   localparam int PendW      = $clog2(Banks + 1);
   localparam int RamAddrW   = BankW + AddrW;
   localparam int RamDepth   = Banks * StoreDepth;

   // Queue of finished loads waiting for the walker.
   localparam int QueueDepth = Banks;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCountW    = $clog2(QueueDepth + 1);

   // Register port.
   localparam int CsrAddrW   = 3;
   localparam int CsrDataW   = 32;
   localparam int RegAddrLsb = 2;

   typedef enum logic [0:0] {
      REG_ROW_COUNT,
      REG_COL_COUNT
   } reg_index_type;

   typedef enum logic [1:0] {
      DIR_RIGHT,
      DIR_DOWN,
      DIR_LEFT,
      DIR_UP
   } dir_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_ADDR,
      BK_DATA
   } back_state_type;

   // One loaded matrix, handed from the loader to the walker.
   typedef struct packed {
      logic [BankW-1:0] bank;
      logic [DimW-1:0]  rows;
      logic [DimW-1:0]  cols;
   } job_type;

   // A size of zero acts as one, a size above the limit acts as the limit.
   function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] value,
                                                  input logic [DimW-1:0] limit);
      logic [DimW-1:0] result;
      result = value;
      if (value == '0) begin
         result = DimW'(1);
      end else if (value > limit) begin
         result = limit;
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/smoe_req_if.sv =====
// Input channel carrying one matrix element per item.
`default_nettype none

interface smoe_req_if import smoe_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [DataW-1:0] element;

   modport source (output valid, output element, input ready);
   modport sink   (input valid, input element, output ready);
endinterface

`default_nettype wire

// ===== hdl/smoe_rsp_if.sv =====
// Result channel carrying one element in spiral order per item.
`default_nettype none

interface smoe_rsp_if import smoe_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [DataW-1:0] element_out;
   logic                    last_out;

   modport source (output valid, output element_out, output last_out, input ready);
   modport sink   (input valid, input element_out, input last_out, output ready);
endinterface

`default_nettype wire

// ===== hdl/smoe_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module smoe_ram #(
   parameter int Width = 32,
   parameter int Depth = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // Write and read in the same cycle; the read data is registered and appears in the following cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/smoe_front.sv =====
// Loader: accepts elements, writes them into a bank and posts each full matrix.
`default_nettype none

module smoe_front import smoe_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   smoe_req_if.sink                 req,
   input  wire logic [DimW-1:0]     rows,
   input  wire logic [DimW-1:0]     cols,
   input  wire logic                clear_load,
   input  wire logic                job_done,
   output logic                     wr_en,
   output logic [RamAddrW-1:0]      wr_addr,
   output logic [DataW-1:0]         wr_data,
   output logic                     push_valid,
   output job_type                  push_job
);

   logic [AddrW-1:0]  load_count_ff, load_count_in;
   logic [BankW-1:0]  bank_ff, bank_in;
   logic [PendW-1:0]  pending_ff, pending_in;
   logic [CountW-1:0] total;
   logic              accept;
   logic              complete;

   // A bank is busy from its last element until the walker has drained it.
   assign req.ready = (pending_ff < PendW'(Banks));
   assign accept    = req.valid && req.ready;
   assign total     = CountW'(rows) * CountW'(cols);
   assign complete  = accept && ((CountW'(load_count_ff) + CountW'(1)) >= total);

   // Element k of a load goes to entry k of the current bank.
   assign wr_en   = accept;
   assign wr_addr = {bank_ff, load_count_ff};
   assign wr_data = req.element;

   assign push_valid    = complete;
   assign push_job.bank = bank_ff;
   assign push_job.rows = rows;
   assign push_job.cols = cols;

   // Next-state logic for the load counter, bank pointer and busy count.
   always_comb begin
      load_count_in = load_count_ff;
      bank_in       = bank_ff;
      priority if (clear_load || complete) begin
         load_count_in = '0;
      end else if (accept) begin
         load_count_in = load_count_ff + AddrW'(1);
      end
      if (complete) begin
         bank_in = bank_ff + BankW'(1);
      end
      pending_in = pending_ff + PendW'(complete) - PendW'(job_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         bank_ff       <= '0;
         pending_ff    <= '0;
      end else begin
         load_count_ff <= load_count_in;
         bank_ff       <= bank_in;
         pending_ff    <= pending_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/smoe_queue.sv =====
// Short queue of loaded matrices between the loader and the walker.
`default_nettype none

`include "spiral_matrix_order_emitter_defines.svh"

module smoe_queue import smoe_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push_valid,
   input  job_type   push_job,
   output logic      pop_valid,
   input  wire logic pop_ready,
   output job_type   pop_job
);

   job_type            entry_ff [QueueDepth];
   logic [QPtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCountW-1:0] count_ff, count_in;
   logic               pop;

   assign pop_valid = (count_ff != '0);
   assign pop_job   = entry_ff[rd_ptr_ff];
   assign pop       = pop_valid && pop_ready;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push_valid) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + QPtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + QPtrW'(1);
      end
      count_in = count_ff + QCountW'(push_valid) - QCountW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   // The loader's bank accounting must keep the queue from overflowing.
   `SMOE_ASSERT_IMPLY(queue_no_overflow, clock, reset, push_valid,
      count_ff != QCountW'(QueueDepth), "queue pushed while full")

endmodule

`default_nettype wire

// ===== hdl/smoe_back.sv =====
// Walker: reads a loaded bank in clockwise spiral order and drives the result channel.
`default_nettype none

`include "spiral_matrix_order_emitter_defines.svh"

module smoe_back import smoe_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                pop_valid,
   input  job_type                  pop_job,
   output logic                     pop_ready,
   output logic [RamAddrW-1:0]      rd_addr,
   input  wire logic [DataW-1:0]    rd_data,
   output logic                     job_done,
   smoe_rsp_if.source               rsp
);

   back_state_type    state_ff, state_in;
   job_type           job_ff, job_in;
   dir_type           dir_ff, dir_in;
   logic [RowW-1:0]   row_ff, row_in;
   logic [ColW-1:0]   col_ff, col_in;
   logic [RowW-1:0]   top_ff, top_in;
   logic [RowW-1:0]   bottom_ff, bottom_in;
   logic [ColW-1:0]   left_ff, left_in;
   logic [ColW-1:0]   right_ff, right_in;
   logic [CountW-1:0] remain_ff, remain_in;
   logic              out_valid_ff, out_valid_in;
   logic [DataW-1:0]  out_element_ff, out_element_in;
   logic              out_last_ff, out_last_in;
   logic [CountW-1:0] lin;
   logic              out_free;
   logic              out_load;

   // Row-major entry of the current position inside the job's bank.
   assign lin     = CountW'(row_ff) * CountW'(job_ff.cols) + CountW'(col_ff);
   assign rd_addr = {job_ff.bank, lin[AddrW-1:0]};

   assign out_free = !out_valid_ff || rsp.ready;

   // Walk control: start a job, wait for read data, hand it over and step.
   always_comb begin
      state_in  = state_ff;
      job_in    = job_ff;
      dir_in    = dir_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      top_in    = top_ff;
      bottom_in = bottom_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      remain_in = remain_ff;
      pop_ready = 1'b0;
      job_done  = 1'b0;
      out_load  = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               job_in    = pop_job;
               dir_in    = DIR_RIGHT;
               row_in    = '0;
               col_in    = '0;
               top_in    = '0;
               left_in   = '0;
               bottom_in = RowW'(pop_job.rows - DimW'(1));
               right_in  = ColW'(pop_job.cols - DimW'(1));
               remain_in = CountW'(pop_job.rows) * CountW'(pop_job.cols);
               state_in  = BK_ADDR;
            end
         end
         BK_ADDR: begin
            state_in = BK_DATA;
         end
         BK_DATA: begin
            if (out_free) begin
               out_load = 1'b1;
               if (remain_ff == CountW'(1)) begin
                  job_done = 1'b1;
                  state_in = BK_IDLE;
               end else begin
                  remain_in = remain_ff - CountW'(1);
                  state_in  = BK_ADDR;
                  // At the end of a side, pull that boundary in and turn clockwise.
                  unique case (dir_ff)
                     DIR_RIGHT: begin
                        if (col_ff < right_ff) begin
                           col_in = col_ff + ColW'(1);
                        end else begin
                           top_in = top_ff + RowW'(1);
                           dir_in = DIR_DOWN;
                           row_in = row_ff + RowW'(1);
                        end
                     end
                     DIR_DOWN: begin
                        if (row_ff < bottom_ff) begin
                           row_in = row_ff + RowW'(1);
                        end else begin
                           right_in = right_ff - ColW'(1);
                           dir_in   = DIR_LEFT;
                           col_in   = col_ff - ColW'(1);
                        end
                     end
                     DIR_LEFT: begin
                        if (col_ff > left_ff) begin
                           col_in = col_ff - ColW'(1);
                        end else begin
                           bottom_in = bottom_ff - RowW'(1);
                           dir_in    = DIR_UP;
                           row_in    = row_ff - RowW'(1);
                        end
                     end
                     DIR_UP: begin
                        if (row_ff > top_ff) begin
                           row_in = row_ff - RowW'(1);
                        end else begin
                           left_in = left_ff + ColW'(1);
                           dir_in  = DIR_RIGHT;
                           col_in  = col_ff + ColW'(1);
                        end
                     end
                     default: begin
                        dir_in = dir_ff;
                     end
                  endcase
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Output register: loads when empty or being drained.
   always_comb begin
      out_valid_in   = out_valid_ff;
      out_element_in = out_element_ff;
      out_last_in    = out_last_ff;
      if (out_load) begin
         out_valid_in   = 1'b1;
         out_element_in = rd_data;
         out_last_in    = (remain_ff == CountW'(1));
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Walk position and result payload need no reset.
   always_ff @(posedge clock) begin
      job_ff         <= job_in;
      dir_ff         <= dir_in;
      row_ff         <= row_in;
      col_ff         <= col_in;
      top_ff         <= top_in;
      bottom_ff      <= bottom_in;
      left_ff        <= left_in;
      right_ff       <= right_in;
      remain_ff      <= remain_in;
      out_element_ff <= out_element_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.element_out = out_element_ff;
   assign rsp.last_out    = out_last_ff;

   // The walk never leaves the loaded matrix while elements remain.
   `SMOE_ASSERT_IMPLY(back_addr_in_range, clock, reset, state_ff != BK_IDLE,
      (DimW'(row_ff) < job_ff.rows) && (DimW'(col_ff) < job_ff.cols) && (remain_ff != '0),
      "spiral walk left the matrix")

   // Finishing a job puts the marked final element on the result channel.
   `SMOE_ASSERT_NEXT(back_done_last, clock, reset, job_done,
      rsp.valid && rsp.last_out, "job finished without a final element")

endmodule

`default_nettype wire

// ===== hdl/spiral_matrix_order_emitter.sv =====
// Top level of the spiral matrix order emitter: registers, loader, queue, RAM and walker.
//
//   Channel   Direction  Handshake          Payload
//   req_chan  in         valid/ready        element (signed 32)
//   rsp_chan  out        valid/ready        element_out (signed 32), last_out
//   csr_*     in/out     APB, pready high   row_count @0x0, col_count @0x4
//
// Loading takes one element per cycle unless both banks are busy; each result passes a RAM
// address state and a registered read data state, and each matrix starts from idle.
// Two RAM banks let the next matrix load while the previous one is walked out.
// The input stalls only while both banks hold matrices not yet fully emitted.
// The result stage holds its item while rsp_chan.ready is low and the walk waits.
// Reset is synchronous; it clears the counts and sets both sizes to one.
`default_nettype none

module spiral_matrix_order_emitter import smoe_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   smoe_req_if.sink                 req_chan,
   smoe_rsp_if.source               rsp_chan,
   input  wire logic                csr_psel,
   input  wire logic                csr_penable,
   input  wire logic                csr_pwrite,
   input  wire logic [CsrAddrW-1:0] csr_paddr,
   input  wire logic [CsrDataW-1:0] csr_pwdata,
   output logic      [CsrDataW-1:0] csr_prdata,
   output logic                     csr_pready
);

   logic [DimW-1:0]     row_count_ff, row_count_in;
   logic [DimW-1:0]     col_count_ff, col_count_in;
   logic [DimW-1:0]     rows_eff;
   logic [DimW-1:0]     cols_eff;
   reg_index_type       reg_sel;
   logic                csr_write;
   logic                wr_en;
   logic [RamAddrW-1:0] wr_addr;
   logic [DataW-1:0]    wr_data;
   logic [RamAddrW-1:0] rd_addr;
   logic [DataW-1:0]    rd_data;
   logic                push_valid;
   job_type             push_job;
   logic                pop_valid;
   logic                pop_ready;
   job_type             pop_job;
   logic                job_done;

   // Register port decode.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = reg_index_type'(csr_paddr[RegAddrLsb]);

   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      csr_prdata   = '0;
      unique case (reg_sel)
         REG_ROW_COUNT: begin
            csr_prdata = CsrDataW'(row_count_ff);
            if (csr_write) begin
               row_count_in = csr_pwdata[DimW-1:0];
            end
         end
         REG_COL_COUNT: begin
            csr_prdata = CsrDataW'(col_count_ff);
            if (csr_write) begin
               col_count_in = csr_pwdata[DimW-1:0];
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= DimW'(1);
         col_count_ff <= DimW'(1);
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // Sizes as the datapath sees them.
   assign rows_eff = clamp_dim(row_count_ff, DimW'(MaxRows));
   assign cols_eff = clamp_dim(col_count_ff, DimW'(MaxCols));

   smoe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rows       (rows_eff),
      .cols       (cols_eff),
      .clear_load (csr_write),
      .job_done   (job_done),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .push_valid (push_valid),
      .push_job   (push_job)
   );

   smoe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   smoe_ram #(
      .Width (DataW),
      .Depth (RamDepth)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   smoe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_job   (pop_job),
      .pop_ready (pop_ready),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .job_done  (job_done),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire
